// File: src/ipas_pkg.sv
// ----------------------------------------------------------------------------
// ipas_pkg
// Types, widths and helpers shared by the im2col patch address sequencer.
// ----------------------------------------------------------------------------
package ipas_pkg;

	localparam int ADDR_BITS_DEF  = 24;
	localparam int BATCH_ROWS_DEF = 48;
	localparam int STRIDE_H_DEF   = 1;
	localparam int STRIDE_W_DEF   = 1;
	localparam int PAD_H_DEF      = 0;
	localparam int PAD_W_DEF      = 0;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int FADDR_W = 24;
	localparam int SLOT_W  = 6;
	localparam int COL_W   = 9;
	localparam int GRP_W   = 9;
	localparam int CHAN_W  = 9;
	localparam int POS_W   = 10;
	localparam int KER_W   = 4;
	localparam int LIM_W   = 11;

	localparam logic [LIM_W-1:0] CAP_CHAN = 11'd512;
	localparam logic [LIM_W-1:0] CAP_GRP  = 11'd512;
	localparam logic [LIM_W-1:0] CAP_POS  = 11'd1024;
	localparam logic [LIM_W-1:0] CAP_KER  = 11'd16;

	typedef enum logic [2:0] {
		REG_CPG = 3'd0,
		REG_IN_H = 3'd1,
		REG_IN_W = 3'd2,
		REG_OUT_H = 3'd3,
		REG_OUT_W = 3'd4,
		REG_GROUPS = 3'd5,
		REG_KER_H = 3'd6,
		REG_KER_W = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [9:0]  channels_per_group;
		logic [10:0] in_height;
		logic [10:0] in_width;
		logic [10:0] out_height;
		logic [10:0] out_width;
		logic [9:0]  groups;
		logic [4:0]  kernel_height;
		logic [4:0]  kernel_width;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul2;
		logic mul3;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL2,
		ST_MUL3,
		ST_FIN
	} state_t;

	// zero acts as one, values above the counter capacity saturate
	function automatic logic [LIM_W-1:0] eff(input logic [LIM_W-1:0] v,
			input logic [LIM_W-1:0] cap);
		logic [LIM_W-1:0] r;
		if (v == '0) begin
			r = LIM_W'(1);
		end else if (v > cap) begin
			r = cap;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: src/ipas_regs.sv
// ----------------------------------------------------------------------------
// ipas_regs
// APB configuration registers of the patch address sequencer.
// ----------------------------------------------------------------------------
module ipas_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ipas_pkg::PADDR_W-1:0]  paddr,
	input  logic [ipas_pkg::PDATA_W-1:0]  pwdata,
	output logic [ipas_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output ipas_pkg::cfg_t                cfg
);
	import ipas_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels_per_group <= 10'd1;
			cfg_q.in_height          <= 11'd1;
			cfg_q.in_width           <= 11'd1;
			cfg_q.out_height         <= 11'd1;
			cfg_q.out_width          <= 11'd1;
			cfg_q.groups             <= 10'd1;
			cfg_q.kernel_height      <= 5'd1;
			cfg_q.kernel_width       <= 5'd1;
		end else if (wr) begin
			unique case (idx)
				REG_CPG:    cfg_q.channels_per_group <= pwdata[9:0];
				REG_IN_H:   cfg_q.in_height          <= pwdata[10:0];
				REG_IN_W:   cfg_q.in_width           <= pwdata[10:0];
				REG_OUT_H:  cfg_q.out_height         <= pwdata[10:0];
				REG_OUT_W:  cfg_q.out_width          <= pwdata[10:0];
				REG_GROUPS: cfg_q.groups             <= pwdata[9:0];
				REG_KER_H:  cfg_q.kernel_height      <= pwdata[4:0];
				REG_KER_W:  cfg_q.kernel_width       <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CPG:    prdata = PDATA_W'(cfg_q.channels_per_group);
			REG_IN_H:   prdata = PDATA_W'(cfg_q.in_height);
			REG_IN_W:   prdata = PDATA_W'(cfg_q.in_width);
			REG_OUT_H:  prdata = PDATA_W'(cfg_q.out_height);
			REG_OUT_W:  prdata = PDATA_W'(cfg_q.out_width);
			REG_GROUPS: prdata = PDATA_W'(cfg_q.groups);
			REG_KER_H:  prdata = PDATA_W'(cfg_q.kernel_height);
			REG_KER_W:  prdata = PDATA_W'(cfg_q.kernel_width);
			default:    prdata = '0;
		endcase
	end

endmodule

// File: src/ipas_ctrl.sv
// ----------------------------------------------------------------------------
// ipas_ctrl
// Sequencer FSM: accept, two multiply steps, then hand off to the output.
// ----------------------------------------------------------------------------
module ipas_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ipas_pkg::stat_t stat,
	output ipas_pkg::cmd_t  cmd
);
	import ipas_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL2;
				end
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !stat.out_busy)
		else $error("result written while output holds an untaken beat");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("new beat accepted while an item is in progress");

endmodule

// File: src/ipas_dp.sv
// ----------------------------------------------------------------------------
// ipas_dp
// Datapath: patch counters, padding check, address multiply chain and
// output register.
// ----------------------------------------------------------------------------
module ipas_dp #(
	parameter int ADDR_BITS  = ipas_pkg::ADDR_BITS_DEF,
	parameter int BATCH_ROWS = ipas_pkg::BATCH_ROWS_DEF,
	parameter int STRIDE_H   = ipas_pkg::STRIDE_H_DEF,
	parameter int STRIDE_W   = ipas_pkg::STRIDE_W_DEF,
	parameter int PAD_H      = ipas_pkg::PAD_H_DEF,
	parameter int PAD_W      = ipas_pkg::PAD_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ipas_pkg::cfg_t               cfg,
	input  ipas_pkg::cmd_t               cmd,
	output ipas_pkg::stat_t              stat,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ipas_pkg::FADDR_W-1:0] feature_address,
	output logic                         is_padding,
	output logic                         address_overflow,
	output logic [ipas_pkg::SLOT_W-1:0]  batch_row,
	output logic [ipas_pkg::COL_W-1:0]   patch_column,
	output logic [ipas_pkg::GRP_W-1:0]   group_index,
	output logic                         last_of_patch,
	output logic                         last_of_batch,
	output logic                         last_of_layer
);
	import ipas_pkg::*;

	localparam int IHW = $clog2(1023 * STRIDE_H + 16);
	localparam int IWW = $clog2(1023 * STRIDE_W + 16);
	localparam int CHW = (IHW > 12) ? IHW + 1 : 13;
	localparam int CWW = (IWW > 12) ? IWW + 1 : 13;
	localparam int T1W = 18;
	localparam int T2W = 29;
	localparam int T3W = 40;
	localparam logic [SLOT_W:0] SLOT_LAST = (SLOT_W+1)'(BATCH_ROWS - 1);

	// counters name the element the next beat emits
	logic [GRP_W-1:0]  grp_q;
	logic [POS_W-1:0]  row_q, colp_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CHAN_W-1:0] chan_q;
	logic [KER_W-1:0]  krow_q, kcol_q;
	logic [COL_W-1:0]  pcol_q;

	logic [GRP_W-1:0]  grp_e;
	logic [POS_W-1:0]  row_e, colp_e;
	logic [SLOT_W-1:0] slot_e;
	logic [CHAN_W-1:0] chan_e;
	logic [KER_W-1:0]  krow_e, kcol_e;
	logic [COL_W-1:0]  pcol_e;

	logic [LIM_W-1:0] cpg_n, ng_n, oh_n, ow_n, kh_n, kw_n;
	logic last_kx, last_ky, last_ic, last_patch, last_pos, last_batch, last_layer;
	logic [IHW-1:0] ih_sum;
	logic [IWW-1:0] iw_sum;
	logic pad;
	logic [T1W+1:0] t1;

	logic [10:0]       ih_s1, iw_s1;
	logic              pad_s1, lp_s1, lb_s1, ll_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [COL_W-1:0]  pcol_s1;
	logic [GRP_W-1:0]  grp_s1;
	logic [T1W-1:0]    t1_s1;
	logic [T2W-1:0]    t2_s2;
	logic [T3W-1:0]    t3_s3;
	logic              ovf;

	logic              out_valid_q;
	logic [FADDR_W-1:0] faddr_q;
	logic              pad_q, ovf_q, lp_q, lb_q, ll_q;
	logic [SLOT_W-1:0] slot_q2;
	logic [COL_W-1:0]  pcol_q2;
	logic [GRP_W-1:0]  grp_q2;

	assign grp_e  = restart ? '0 : grp_q;
	assign row_e  = restart ? '0 : row_q;
	assign colp_e = restart ? '0 : colp_q;
	assign slot_e = restart ? '0 : slot_q;
	assign chan_e = restart ? '0 : chan_q;
	assign krow_e = restart ? '0 : krow_q;
	assign kcol_e = restart ? '0 : kcol_q;
	assign pcol_e = restart ? '0 : pcol_q;

	always_comb begin
		cpg_n = eff(LIM_W'(cfg.channels_per_group), CAP_CHAN);
		ng_n  = eff(LIM_W'(cfg.groups), CAP_GRP);
		oh_n  = eff(cfg.out_height, CAP_POS);
		ow_n  = eff(cfg.out_width, CAP_POS);
		kh_n  = eff(LIM_W'(cfg.kernel_height), CAP_KER);
		kw_n  = eff(LIM_W'(cfg.kernel_width), CAP_KER);

		last_kx    = LIM_W'(kcol_e) >= kw_n - LIM_W'(1);
		last_ky    = LIM_W'(krow_e) >= kh_n - LIM_W'(1);
		last_ic    = LIM_W'(chan_e) >= cpg_n - LIM_W'(1);
		last_patch = last_kx && last_ky && last_ic;
		last_pos   = (LIM_W'(row_e) >= oh_n - LIM_W'(1))
			&& (LIM_W'(colp_e) >= ow_n - LIM_W'(1));
		last_batch = last_patch && (((SLOT_W+1)'(slot_e) >= SLOT_LAST) || last_pos);
		last_layer = last_patch && last_pos && (LIM_W'(grp_e) >= ng_n - LIM_W'(1));

		ih_sum = IHW'(row_e) * IHW'(STRIDE_H) + IHW'(krow_e);
		iw_sum = IWW'(colp_e) * IWW'(STRIDE_W) + IWW'(kcol_e);
		pad = (CHW'(ih_sum) < CHW'(PAD_H))
			|| (CHW'(ih_sum) >= CHW'(cfg.in_height) + CHW'(PAD_H))
			|| (CWW'(iw_sum) < CWW'(PAD_W))
			|| (CWW'(iw_sum) >= CWW'(cfg.in_width) + CWW'(PAD_W));

		t1 = (T1W+2)'(grp_e) * (T1W+2)'(cpg_n) + (T1W+2)'(chan_e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q  <= '0;
			row_q  <= '0;
			colp_q <= '0;
			slot_q <= '0;
			chan_q <= '0;
			krow_q <= '0;
			kcol_q <= '0;
			pcol_q <= '0;
		end else if (cmd.load) begin
			if (last_patch) begin
				kcol_q <= '0;
				krow_q <= '0;
				chan_q <= '0;
				pcol_q <= '0;
				if (last_pos) begin
					row_q  <= '0;
					colp_q <= '0;
					slot_q <= '0;
					grp_q  <= (LIM_W'(grp_e) >= ng_n - LIM_W'(1)) ? '0 : grp_e + 1'b1;
				end else begin
					slot_q <= last_batch ? '0 : slot_e + 1'b1;
					grp_q  <= grp_e;
					if (LIM_W'(colp_e) >= ow_n - LIM_W'(1)) begin
						colp_q <= '0;
						row_q  <= row_e + 1'b1;
					end else begin
						colp_q <= colp_e + 1'b1;
						row_q  <= row_e;
					end
				end
			end else begin
				grp_q  <= grp_e;
				row_q  <= row_e;
				colp_q <= colp_e;
				slot_q <= slot_e;
				pcol_q <= pcol_e + 1'b1;
				if (last_kx) begin
					kcol_q <= '0;
					if (last_ky) begin
						krow_q <= '0;
						chan_q <= chan_e + 1'b1;
					end else begin
						krow_q <= krow_e + 1'b1;
						chan_q <= chan_e;
					end
				end else begin
					kcol_q <= kcol_e + 1'b1;
					krow_q <= krow_e;
					chan_q <= chan_e;
				end
			end
		end
	end

	// address chain: ((g*cpg + c)*in_h + ih)*in_w + iw
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ih_s1   <= 11'(ih_sum - IHW'(PAD_H));
			iw_s1   <= 11'(iw_sum - IWW'(PAD_W));
			pad_s1  <= pad;
			lp_s1   <= last_patch;
			lb_s1   <= last_batch;
			ll_s1   <= last_layer;
			slot_s1 <= slot_e;
			pcol_s1 <= pcol_e;
			grp_s1  <= grp_e;
			t1_s1   <= T1W'(t1);
		end
		if (cmd.mul2) begin
			t2_s2 <= T2W'(T2W'(t1_s1) * T2W'(cfg.in_height) + T2W'(ih_s1));
		end
		if (cmd.mul3) begin
			t3_s3 <= T3W'(t2_s2) * T3W'(cfg.in_width) + T3W'(iw_s1);
		end
	end

	assign ovf = !pad_s1 && (t3_s3[T3W-1:ADDR_BITS] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			faddr_q <= (pad_s1 || ovf) ? '0 : t3_s3[FADDR_W-1:0];
			pad_q   <= pad_s1;
			ovf_q   <= ovf;
			slot_q2 <= slot_s1;
			pcol_q2 <= pcol_s1;
			grp_q2  <= grp_s1;
			lp_q    <= lp_s1;
			lb_q    <= lb_s1;
			ll_q    <= ll_s1;
		end
	end

	assign stat.out_busy  = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign feature_address  = faddr_q;
	assign is_padding       = pad_q;
	assign address_overflow = ovf_q;
	assign batch_row        = slot_q2;
	assign patch_column     = pcol_q2;
	assign group_index      = grp_q2;
	assign last_of_patch    = lp_q;
	assign last_of_batch    = lb_q;
	assign last_of_layer    = ll_q;

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_padding |-> feature_address == '0 && !address_overflow)
		else $error("padding beat carries an address");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && address_overflow |-> feature_address == '0)
		else $error("overflow beat carries an address");

	a_layer_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_layer |-> last_of_batch && last_of_patch)
		else $error("end of layer without end of batch and patch");

endmodule

// File: src/im2col_patch_address_sequencer_unit.sv
// The result beat is registered once the FSM has walked the load step, the two
// registered multiplies of the address chain and the output step; no new item is
// taken before the output step of the last one.
// A result waiting at the output holds the next item in its output step; no
// further input beat is taken until the waiting beat leaves.
// Reset (arst_n low, async): patch counters cleared, registers set to 1.
// ----------------------------------------------------------------------------
// im2col_patch_address_sequencer_unit
// Address sequencer for the im2col gather of a grouped 2-D convolution.
// ----------------------------------------------------------------------------
module im2col_patch_address_sequencer_unit #(
	parameter int ADDR_BITS  = ipas_pkg::ADDR_BITS_DEF,
	parameter int BATCH_ROWS = ipas_pkg::BATCH_ROWS_DEF,
	parameter int STRIDE_H   = ipas_pkg::STRIDE_H_DEF,
	parameter int STRIDE_W   = ipas_pkg::STRIDE_W_DEF,
	parameter int PAD_H      = ipas_pkg::PAD_H_DEF,
	parameter int PAD_W      = ipas_pkg::PAD_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipas_pkg::PADDR_W-1:0] paddr,
	input  logic [ipas_pkg::PDATA_W-1:0] pwdata,
	output logic [ipas_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ipas_pkg::FADDR_W-1:0] feature_address,
	output logic                         is_padding,
	output logic                         address_overflow,
	output logic [ipas_pkg::SLOT_W-1:0]  batch_row,
	output logic [ipas_pkg::COL_W-1:0]   patch_column,
	output logic [ipas_pkg::GRP_W-1:0]   group_index,
	output logic                         last_of_patch,
	output logic                         last_of_batch,
	output logic                         last_of_layer
);
	import ipas_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	ipas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ipas_dp #(
		.ADDR_BITS  (ADDR_BITS),
		.BATCH_ROWS (BATCH_ROWS),
		.STRIDE_H   (STRIDE_H),
		.STRIDE_W   (STRIDE_W),
		.PAD_H      (PAD_H),
		.PAD_W      (PAD_W)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.stat             (stat),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.feature_address  (feature_address),
		.is_padding       (is_padding),
		.address_overflow (address_overflow),
		.batch_row        (batch_row),
		.patch_column     (patch_column),
		.group_index      (group_index),
		.last_of_patch    (last_of_patch),
		.last_of_batch    (last_of_batch),
		.last_of_layer    (last_of_layer)
	);

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the im2col patch address sequencer beat by beat. A local model of the
// patch walk (group, position, channel, kernel row, kernel column) predicts
// every result beat. Directed beats cover reset values, zero and saturated
// registers, empty input maps, address overflow and registers shrunk below a
// running counter. Random layer shapes and random stalls on both sides follow.
// ----------------------------------------------------------------------------
module tb_top;
	import ipas_pkg::*;

	typedef struct packed {
		logic [FADDR_W-1:0] feature_address;
		logic               is_padding;
		logic               address_overflow;
		logic [SLOT_W-1:0]  batch_row;
		logic [COL_W-1:0]   patch_column;
		logic [GRP_W-1:0]   group_index;
		logic               last_of_patch;
		logic               last_of_batch;
		logic               last_of_layer;
	} patch_beat_t;

	typedef struct {
		bit          is_cfg;
		reg_idx_t    ri;
		logic [31:0] val;
		logic        rst;
		bit          typed;
		patch_beat_t want;
	} stim_row_t;

	localparam patch_beat_t LONE_BEAT = '{feature_address: '0, is_padding: 1'b0,
		address_overflow: 1'b0, batch_row: '0, patch_column: '0, group_index: '0,
		last_of_patch: 1'b1, last_of_batch: 1'b1, last_of_layer: 1'b1};
	localparam patch_beat_t LONE_PAD_BEAT = '{feature_address: '0, is_padding: 1'b1,
		address_overflow: 1'b0, batch_row: '0, patch_column: '0, group_index: '0,
		last_of_patch: 1'b1, last_of_batch: 1'b1, last_of_layer: 1'b1};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               restart = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [FADDR_W-1:0] feature_address;
	logic               is_padding;
	logic               address_overflow;
	logic [SLOT_W-1:0]  batch_row;
	logic [COL_W-1:0]   patch_column;
	logic [GRP_W-1:0]   group_index;
	logic               last_of_patch;
	logic               last_of_batch;
	logic               last_of_layer;

	im2col_patch_address_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.feature_address(feature_address),
		.is_padding(is_padding),
		.address_overflow(address_overflow),
		.batch_row(batch_row),
		.patch_column(patch_column),
		.group_index(group_index),
		.last_of_patch(last_of_patch),
		.last_of_batch(last_of_batch),
		.last_of_layer(last_of_layer)
	);

	// shadow registers and walk counters
	cfg_t              geom;
	logic [GRP_W-1:0]  grp_cnt;
	logic [POS_W-1:0]  row_cnt;
	logic [POS_W-1:0]  col_cnt;
	logic [SLOT_W-1:0] slot_cnt;
	logic [CHAN_W-1:0] ch_cnt;
	logic [KER_W-1:0]  ky_cnt;
	logic [KER_W-1:0]  kx_cnt;
	logic [COL_W-1:0]  pcol_cnt;

	patch_beat_t pending_elements[$];
	stim_row_t   directed_rows[$];
	int          err_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_count(input int v, input int cap);
		if (v == 0) begin
			return 1;
		end
		return (v > cap) ? cap : v;
	endfunction

	function automatic void clear_walk();
		grp_cnt = '0;
		row_cnt = '0;
		col_cnt = '0;
		slot_cnt = '0;
		ch_cnt = '0;
		ky_cnt = '0;
		kx_cnt = '0;
		pcol_cnt = '0;
	endfunction

	// emits the element the counters point at, then steps the walk
	function automatic patch_beat_t next_patch_element(input logic rst);
		patch_beat_t r;
		int cpg, ng, oh, ow, kh, kw;
		longint ih, iw, addr;
		bit pad, ovf, l_kx, l_ky, l_ch, l_patch, l_pos, l_batch, l_layer;

		if (rst) begin
			clear_walk();
		end
		cpg = clamp_count(int'(geom.channels_per_group), 512);
		ng = clamp_count(int'(geom.groups), 512);
		oh = clamp_count(int'(geom.out_height), 1024);
		ow = clamp_count(int'(geom.out_width), 1024);
		kh = clamp_count(int'(geom.kernel_height), 16);
		kw = clamp_count(int'(geom.kernel_width), 16);

		ih = longint'(row_cnt) * STRIDE_H_DEF + longint'(ky_cnt) - PAD_H_DEF;
		iw = longint'(col_cnt) * STRIDE_W_DEF + longint'(kx_cnt) - PAD_W_DEF;
		pad = ih < 0 || ih >= longint'(geom.in_height) || iw < 0
			|| iw >= longint'(geom.in_width);
		addr = 0;
		ovf = 0;
		if (!pad) begin
			addr = ((longint'(grp_cnt) * cpg + longint'(ch_cnt)) * longint'(geom.in_height)
				+ ih) * longint'(geom.in_width) + iw;
			if ((addr >> ADDR_BITS_DEF) != 0) begin
				ovf = 1;
				addr = 0;
			end
		end

		l_kx = int'(kx_cnt) >= kw - 1;
		l_ky = int'(ky_cnt) >= kh - 1;
		l_ch = int'(ch_cnt) >= cpg - 1;
		l_patch = l_kx && l_ky && l_ch;
		l_pos = int'(row_cnt) >= oh - 1 && int'(col_cnt) >= ow - 1;
		l_batch = l_patch && (int'(slot_cnt) >= BATCH_ROWS_DEF - 1 || l_pos);
		l_layer = l_patch && l_pos && int'(grp_cnt) >= ng - 1;

		r.feature_address = addr[FADDR_W-1:0];
		r.is_padding = pad;
		r.address_overflow = ovf;
		r.batch_row = slot_cnt;
		r.patch_column = pcol_cnt;
		r.group_index = grp_cnt;
		r.last_of_patch = l_patch;
		r.last_of_batch = l_batch;
		r.last_of_layer = l_layer;

		if (l_patch) begin
			kx_cnt = '0;
			ky_cnt = '0;
			ch_cnt = '0;
			pcol_cnt = '0;
			slot_cnt = l_batch ? '0 : slot_cnt + 1'b1;
			if (l_pos) begin
				row_cnt = '0;
				col_cnt = '0;
				slot_cnt = '0;
				grp_cnt = (int'(grp_cnt) >= ng - 1) ? '0 : grp_cnt + 1'b1;
			end else if (int'(col_cnt) >= ow - 1) begin
				col_cnt = '0;
				row_cnt = row_cnt + 1'b1;
			end else begin
				col_cnt = col_cnt + 1'b1;
			end
		end else begin
			pcol_cnt = pcol_cnt + 1'b1;
			if (l_kx) begin
				kx_cnt = '0;
				if (l_ky) begin
					ky_cnt = '0;
					ch_cnt = ch_cnt + 1'b1;
				end else begin
					ky_cnt = ky_cnt + 1'b1;
				end
			end else begin
				kx_cnt = kx_cnt + 1'b1;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : result_check
		patch_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_elements.size() == 0) begin
				$error("result beat with no expectation pending");
				err_count++;
			end else begin
				e = pending_elements.pop_front();
				check_field("feature_address", e.feature_address, feature_address);
				check_field("is_padding", e.is_padding, is_padding);
				check_field("address_overflow", e.address_overflow, address_overflow);
				check_field("batch_row", e.batch_row, batch_row);
				check_field("patch_column", e.patch_column, patch_column);
				check_field("group_index", e.group_index, group_index);
				check_field("last_of_patch", e.last_of_patch, last_of_patch);
				check_field("last_of_batch", e.last_of_batch, last_of_batch);
				check_field("last_of_layer", e.last_of_layer, last_of_layer);
			end
		end
	end

	task automatic write_reg(input reg_idx_t ri, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(ri));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (ri)
			REG_CPG: geom.channels_per_group = v[9:0];
			REG_IN_H: geom.in_height = v[10:0];
			REG_IN_W: geom.in_width = v[10:0];
			REG_OUT_H: geom.out_height = v[10:0];
			REG_OUT_W: geom.out_width = v[10:0];
			REG_GROUPS: geom.groups = v[9:0];
			REG_KER_H: geom.kernel_height = v[4:0];
			REG_KER_W: geom.kernel_width = v[4:0];
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_geometry(input cfg_t c);
		reg_idx_t ri;
		logic [31:0] f, noise;
		for (int i = 0; i < 8; i++) begin
			ri = reg_idx_t'(i);
			case (ri)
				REG_CPG: f = 32'(c.channels_per_group);
				REG_IN_H: f = 32'(c.in_height);
				REG_IN_W: f = 32'(c.in_width);
				REG_OUT_H: f = 32'(c.out_height);
				REG_OUT_W: f = 32'(c.out_width);
				REG_GROUPS: f = 32'(c.groups);
				REG_KER_H: f = 32'(c.kernel_height);
				REG_KER_W: f = 32'(c.kernel_width);
			endcase
			// junk above the field width must be dropped
			noise = ($urandom_range(3) == 0) ? $urandom : 32'd0;
			write_reg(ri, (noise & 32'hFFFF_F800) | f);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_elements.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic send_beat(input logic rst, input bit typed = 0,
			input patch_beat_t want = '0);
		patch_beat_t pred;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) begin
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		restart <= rst;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pred = next_patch_element(rst);
		pending_elements.push_back(typed ? want : pred);
	endtask

	function automatic void add_cfg(input reg_idx_t ri, input logic [31:0] v);
		stim_row_t r;
		r.is_cfg = 1;
		r.ri = ri;
		r.val = v;
		r.rst = 1'b0;
		r.typed = 0;
		r.want = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_beat(input logic rst, input bit typed = 0,
			input patch_beat_t want = '0);
		stim_row_t r;
		r.is_cfg = 0;
		r.ri = REG_CPG;
		r.val = '0;
		r.rst = rst;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	function automatic cfg_t pick_geometry();
		cfg_t c;
		int flavor;
		flavor = $urandom_range(2);
		case (flavor)
			0: begin
				// tiny layers: ends of layer come often
				c.channels_per_group = 10'($urandom_range(1, 2));
				c.in_height = 11'($urandom_range(1, 3));
				c.in_width = 11'($urandom_range(1, 3));
				c.out_height = 11'($urandom_range(1, 2));
				c.out_width = 11'($urandom_range(1, 2));
				c.groups = 10'($urandom_range(1, 3));
				c.kernel_height = 5'($urandom_range(1, 2));
				c.kernel_width = 5'($urandom_range(1, 2));
			end
			1: begin
				// many short patches: batches fill up
				c.channels_per_group = 10'd1;
				c.in_height = 11'($urandom_range(1, 9));
				c.in_width = 11'($urandom_range(1, 9));
				c.out_height = 11'($urandom_range(6, 9));
				c.out_width = 11'($urandom_range(6, 9));
				c.groups = 10'($urandom_range(1, 2));
				c.kernel_height = 5'd1;
				c.kernel_width = 5'($urandom_range(1, 2));
			end
			default: begin
				c.channels_per_group = 10'($urandom_range(1, 3));
				c.in_height = 11'($urandom_range(1, 8));
				c.in_width = 11'($urandom_range(1, 8));
				c.out_height = 11'($urandom_range(1, 5));
				c.out_width = 11'($urandom_range(1, 5));
				c.groups = 10'($urandom_range(1, 3));
				c.kernel_height = 5'($urandom_range(1, 4));
				c.kernel_width = 5'($urandom_range(1, 4));
			end
		endcase
		// occasional zero or all-ones register
		if ($urandom_range(99) < 8) c.channels_per_group = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(99) < 8) c.in_height = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(99) < 8) c.in_width = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(99) < 8) c.out_height = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(99) < 8) c.out_width = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(99) < 8) c.groups = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(99) < 8) c.kernel_height = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(99) < 8) c.kernel_width = $urandom_range(1) ? '1 : '0;
		return c;
	endfunction

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int n, sent;

		geom = '{channels_per_group: 10'd1, in_height: 11'd1, in_width: 11'd1,
			out_height: 11'd1, out_width: 11'd1, groups: 10'd1,
			kernel_height: 5'd1, kernel_width: 5'd1};
		clear_walk();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 52;

		// reset values: every beat is a whole one-element layer
		add_beat(1'b0, 1, LONE_BEAT);
		add_beat(1'b1, 1, LONE_BEAT);
		add_beat(1'b0, 1, LONE_BEAT);
		// empty input map
		add_cfg(REG_IN_H, 32'd0);
		add_beat(1'b0, 1, LONE_PAD_BEAT);
		add_cfg(REG_IN_H, 32'd1);
		add_cfg(REG_IN_W, 32'd0);
		add_beat(1'b1, 1, LONE_PAD_BEAT);
		add_cfg(REG_IN_W, 32'd1);
		// zero counts behave as one
		add_cfg(REG_CPG, 32'd0);
		add_cfg(REG_OUT_H, 32'd0);
		add_cfg(REG_OUT_W, 32'd0);
		add_cfg(REG_GROUPS, 32'd0);
		add_cfg(REG_KER_H, 32'd0);
		add_cfg(REG_KER_W, 32'd0);
		add_beat(1'b0, 1, LONE_BEAT);
		// step into the groups, then blow up the map so the address overflows
		add_cfg(REG_GROUPS, 32'd512);
		add_beat(1'b1);
		for (int i = 0; i < 7; i++) add_beat(1'b0);
		add_cfg(REG_CPG, 32'd1023);
		add_cfg(REG_IN_H, 32'd2047);
		add_cfg(REG_IN_W, 32'd2047);
		add_beat(1'b0);
		add_beat(1'b0);
		// saturated kernel, then shrink it under a running column counter
		add_cfg(REG_GROUPS, 32'd1);
		add_cfg(REG_CPG, 32'd1);
		add_cfg(REG_KER_H, 32'd31);
		add_cfg(REG_KER_W, 32'd31);
		add_beat(1'b1);
		for (int i = 0; i < 5; i++) add_beat(1'b0);
		add_cfg(REG_KER_W, 32'd2);
		for (int i = 0; i < 3; i++) add_beat(1'b0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				drain_results();
				write_reg(directed_rows[i].ri, directed_rows[i].val);
			end else begin
				send_beat(directed_rows[i].rst, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 52 : 0;
			recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 34 : 0;
			sent = 0;
			while (sent < 125) begin
				drain_results();
				program_geometry(pick_geometry());
				n = $urandom_range(20, 60);
				if ($urandom_range(1)) begin
					send_beat(1'b1);
				end
				for (int i = 0; i < n; i++) begin
					send_beat($urandom_range(99) < 3);
				end
				sent += n;
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/ipas_pkg.sv
src/ipas_regs.sv
src/ipas_ctrl.sv
src/ipas_dp.sv
src/im2col_patch_address_sequencer_unit.sv
test/tb_top.sv
